// ----- hdl/pat_pkg.sv -----
package pat_pkg;

	// default table depth
	localparam int ENTRIES_DEF = 8;

	// field widths
	localparam int ACTION_W  = 2;
	localparam int ID_W      = 16;
	localparam int TIMEOUT_W = 32;
	localparam int STATUS_W  = 3;
	localparam int SLOT_W    = 3;
	localparam int AMOUNT_W  = 16;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 3;

	// register reset values
	localparam logic [ID_W-1:0]     LIMIT_RST   = 16'd65535;
	localparam logic [AMOUNT_W-1:0] AMOUNT_RST  = 16'd1000;
	localparam logic [ID_W-1:0]     NEXT_ID_RST = 16'd65535;

	// register address bit and indexes
	localparam int                  REG_SEL_BIT   = 2;
	localparam logic                REG_ID_LIMIT  = 1'b0;
	localparam logic                REG_TICK_AMT  = 1'b1;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_ATTACH = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_ACK    = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ATTACHED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ACKED     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TICK_END  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic emit_final;
	} pat_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic stop;
		logic invalid;
		logic out_free;
	} pat_sts_t;

endpackage

// ----- hdl/pat_in_if.sv -----
interface pat_in_if;
	logic                              valid;
	logic                              ready;
	logic [pat_pkg::ACTION_W-1:0]      action;
	logic [pat_pkg::ID_W-1:0]          msg_id;
	logic [pat_pkg::TIMEOUT_W-1:0]     timeout_ms;

	modport source(output valid, action, msg_id, timeout_ms, input ready);
	modport sink(input valid, action, msg_id, timeout_ms, output ready);
endinterface

// ----- hdl/pat_out_if.sv -----
interface pat_out_if;
	logic                              valid;
	logic                              ready;
	logic [pat_pkg::STATUS_W-1:0]      status;
	logic [pat_pkg::ID_W-1:0]          result_id;
	logic [pat_pkg::SLOT_W-1:0]        slot;
	logic                              last;

	modport source(output valid, status, result_id, slot, last, input ready);
	modport sink(input valid, status, result_id, slot, last, output ready);
endinterface

// ----- hdl/pending_ack_table_with_timeout.sv -----
// channel   dir  handshake       payload
// req       in   valid/ready     action, msg_id, timeout_ms
// rsp       out  valid/ready     status, result_id, slot, last
// apb       in   psel/penable    paddr, pwdata, prdata (limit at 0x0, tick amount at 0x4)
//
// an accepted item walks the slots from slot 0, one slot per cycle while no result waits;
// attach and acknowledge end on the first slot that hits, else with a closing result after
// the last slot; tick walks every slot, then gives a closing result; an invalid id goes
// straight to the closing result; no new item is taken until the last one is done; the walk
// reads the single-read-port table memory; a slot with a result, or the closing result,
// waits while the result register is full and not taken; slots without a result never wait
// arst_n resets the live bits, the id counter, the registers and the result valid
module pending_ack_table_with_timeout #(
	parameter int ENTRIES = pat_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pat_in_if.sink                      req,
	pat_out_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pat_pkg::PADDR_W-1:0] paddr,
	input  logic [pat_pkg::PDATA_W-1:0] pwdata,
	output logic [pat_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	pat_pkg::pat_cmd_t cmd;
	pat_pkg::pat_sts_t sts;
	logic [IDX_W-1:0]  idx;
	logic [IDX_W-1:0]  raddr;

	assign pready = 1'b1;

	// sequencer
	pat_ctrl #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd),
		.idx       (idx),
		.raddr     (raddr)
	);

	// table, registers and result register
	pat_dp #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.idx        (idx),
		.raddr      (raddr),
		.action     (req.action),
		.msg_id     (req.msg_id),
		.timeout_ms (req.timeout_ms),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.status     (rsp.status),
		.result_id  (rsp.result_id),
		.slot       (rsp.slot),
		.last       (rsp.last),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata)
	);

endmodule

// ----- hdl/pat_ram.sv -----
module pat_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/pat_ctrl.sv -----
module pat_ctrl #(
	parameter int ENTRIES = pat_pkg::ENTRIES_DEF,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pat_pkg::pat_sts_t sts,
	output pat_pkg::pat_cmd_t cmd,
	output logic [IDX_W-1:0]  idx,
	output logic [IDX_W-1:0]  raddr
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             accept;
	logic             eval;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	// a slot is evaluated unless its result would find the output busy
	assign eval      = (state_q == S_SCAN) && !(sts.hit && !sts.out_free);
	assign idx       = idx_q;

	always_comb begin
		cmd.load       = accept;
		cmd.eval       = eval;
		cmd.emit_final = (state_q == S_FINISH) && sts.out_free;
	end

	// read address runs one slot ahead of the slot being evaluated, or stays on it while it waits
	always_comb begin
		raddr = '0;
		if (state_q == S_SCAN) begin
			if (!eval) begin
				raddr = idx_q;
			end else if (idx_q != LAST_IDX) begin
				raddr = idx_q + IDX_W'(1);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						state_q <= sts.invalid ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (eval) begin
						priority if (sts.hit && sts.stop) begin
							state_q <= S_IDLE;
						end else if (idx_q == LAST_IDX) begin
							state_q <= S_FINISH;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				S_FINISH: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= LAST_IDX))
		else $error("scan index past last slot");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(eval && sts.hit) |-> sts.out_free)
		else $error("result loaded while output busy");
	a_stop_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(eval && sts.hit && sts.stop) |=> (state_q == S_IDLE))
		else $error("scan did not end on terminating hit");
`endif

endmodule

// ----- hdl/pat_dp.sv -----
module pat_dp #(
	parameter int ENTRIES = pat_pkg::ENTRIES_DEF,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pat_pkg::pat_cmd_t                cmd,
	output pat_pkg::pat_sts_t                sts,
	input  logic [IDX_W-1:0]                 idx,
	input  logic [IDX_W-1:0]                 raddr,
	// incoming item fields
	input  logic [pat_pkg::ACTION_W-1:0]     action,
	input  logic [pat_pkg::ID_W-1:0]         msg_id,
	input  logic [pat_pkg::TIMEOUT_W-1:0]    timeout_ms,
	// result register
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pat_pkg::STATUS_W-1:0]     status,
	output logic [pat_pkg::ID_W-1:0]         result_id,
	output logic [pat_pkg::SLOT_W-1:0]       slot,
	output logic                             last,
	// register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pat_pkg::PADDR_W-1:0]      paddr,
	input  logic [pat_pkg::PDATA_W-1:0]      pwdata,
	output logic [pat_pkg::PDATA_W-1:0]      prdata
);

	localparam int ID_W  = pat_pkg::ID_W;
	localparam int TO_W  = pat_pkg::TIMEOUT_W;
	localparam int ROW_W = ID_W + TO_W;

	// configuration
	logic [ID_W-1:0]              limit_q;
	logic [pat_pkg::AMOUNT_W-1:0] amount_q;
	logic                         reg_sel;

	// item latched at accept
	logic [pat_pkg::ACTION_W-1:0] op_q;
	logic [ID_W-1:0]              id_q;
	logic [TO_W-1:0]              to_q;
	logic                         inv_q;
	logic [ID_W-1:0]              next_id_q;
	logic [ID_W-1:0]              alloc_id;

	// table
	logic [ENTRIES-1:0]           live_q;
	logic [ROW_W-1:0]             rdata;
	logic [ROW_W-1:0]             wdata;
	logic                         we;
	logic [ID_W-1:0]              row_id;
	logic [TO_W-1:0]              row_to;
	logic [TO_W-1:0]              amount_ext;
	logic                         live;
	logic                         is_attach;
	logic                         is_ack;
	logic                         is_tick;
	logic                         expire;
	logic                         hit;

	// result register
	logic                         out_valid_q;
	logic [pat_pkg::STATUS_W-1:0] status_q;
	logic [ID_W-1:0]              result_id_q;
	logic [pat_pkg::SLOT_W-1:0]   slot_q;
	logic                         last_q;
	logic                         out_free;

	// register writes and reads
	assign reg_sel = paddr[pat_pkg::REG_SEL_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= pat_pkg::LIMIT_RST;
			amount_q <= pat_pkg::AMOUNT_RST;
		end else if (psel && penable && pwrite) begin
			if (reg_sel == pat_pkg::REG_ID_LIMIT) begin
				limit_q <= pwdata[ID_W-1:0];
			end else begin
				amount_q <= pwdata[pat_pkg::AMOUNT_W-1:0];
			end
		end
	end

	assign prdata = (reg_sel == pat_pkg::REG_TICK_AMT) ?
		pat_pkg::PDATA_W'(amount_q) : pat_pkg::PDATA_W'(limit_q);

	// next packet id, wrapping to 1 past the limit
	assign alloc_id = (next_id_q >= limit_q) ? ID_W'(1) : next_id_q + ID_W'(1);

	// latch item at accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= pat_pkg::NEXT_ID_RST;
		end else if (cmd.load && action == pat_pkg::ACT_ALLOC) begin
			next_id_q <= alloc_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= action;
			id_q  <= (action == pat_pkg::ACT_ALLOC) ? alloc_id : msg_id;
			to_q  <= timeout_ms;
			inv_q <= sts.invalid;
		end
	end

	// slot evaluation
	assign row_id     = rdata[ROW_W-1:TO_W];
	assign row_to     = rdata[TO_W-1:0];
	assign amount_ext = TO_W'(amount_q);
	assign live       = live_q[idx];
	assign is_attach  = (op_q == pat_pkg::ACT_ATTACH) || (op_q == pat_pkg::ACT_ALLOC);
	assign is_ack     = (op_q == pat_pkg::ACT_ACK);
	assign is_tick    = (op_q == pat_pkg::ACT_TICK);
	assign expire     = live && (row_to <= amount_ext);
	assign hit        = (is_attach && !live) || (is_ack && live && row_id == id_q) ||
		(is_tick && expire);

	always_comb begin
		sts.hit      = hit;
		sts.stop     = !is_tick;
		sts.invalid  = ((action == pat_pkg::ACT_ATTACH) || (action == pat_pkg::ACT_ACK)) &&
			(msg_id == '0);
		sts.out_free = out_free;
	end

	// table row write: new entry, or decremented timeout on tick
	assign we    = cmd.eval && ((is_attach && !live) || (is_tick && live && !expire));
	assign wdata = is_attach ? {id_q, to_q} : {row_id, row_to - amount_ext};

	pat_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// live bits: set on attach, cleared on ack or expiry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
		end else if (cmd.eval && hit) begin
			live_q[idx] <= is_attach;
		end
	end

	// result register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.eval && hit) || cmd.emit_final) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && hit) begin
			slot_q <= pat_pkg::SLOT_W'(idx);
			priority if (is_attach) begin
				status_q    <= pat_pkg::ST_ATTACHED;
				result_id_q <= id_q;
				last_q      <= 1'b1;
			end else if (is_ack) begin
				status_q    <= pat_pkg::ST_ACKED;
				result_id_q <= id_q;
				last_q      <= 1'b1;
			end else begin
				status_q    <= pat_pkg::ST_EXPIRED;
				result_id_q <= row_id;
				last_q      <= 1'b0;
			end
		end else if (cmd.emit_final) begin
			slot_q <= '0;
			last_q <= 1'b1;
			priority if (inv_q) begin
				status_q    <= pat_pkg::ST_INVALID;
				result_id_q <= '0;
			end else if (is_attach) begin
				status_q    <= pat_pkg::ST_FULL;
				result_id_q <= id_q;
			end else if (is_ack) begin
				status_q    <= pat_pkg::ST_NOT_FOUND;
				result_id_q <= id_q;
			end else begin
				status_q    <= pat_pkg::ST_TICK_END;
				result_id_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign result_id = result_id_q;
	assign slot      = slot_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_attach_sets_live: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && hit && is_attach) |=> live_q[$past(idx)])
		else $error("attached slot not marked live");
	a_ack_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && hit && !is_attach) |=> !live_q[$past(idx)])
		else $error("acknowledged or expired slot still live");
	a_write_free_or_live: assert property (@(posedge clk) disable iff (!arst_n)
		(we && is_attach) |-> !live)
		else $error("attach overwrote a live slot");
`endif

endmodule

// ----- test/pat_result_checker.sv -----
module pat_result_checker #(
	parameter int ENTRIES = pat_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pat_in_if                           req,
	pat_out_if                          rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pat_pkg::PADDR_W-1:0] paddr,
	input  logic [pat_pkg::PDATA_W-1:0] pwdata,
	input  logic                        pready,
	output int unsigned                 outstanding,
	output int unsigned                 mismatches
);
	import pat_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     result_id;
		logic [SLOT_W-1:0]   slot;
		logic                last;
	} table_result_t;

	// mirror of the table, the id counter and the registers
	logic [ID_W-1:0]      live_id [ENTRIES];
	logic [TIMEOUT_W-1:0] time_left [ENTRIES];
	logic [ID_W-1:0]      id_counter;
	logic [ID_W-1:0]      id_limit;
	logic [AMOUNT_W-1:0]  tick_step;
	table_result_t        awaited_results [$];

	function automatic table_result_t make_result(input logic [STATUS_W-1:0] st,
		input logic [ID_W-1:0] id, input int idx, input logic fin);
		table_result_t res;
		res.status    = st;
		res.result_id = id;
		res.slot      = SLOT_W'(idx);
		res.last      = fin;
		return res;
	endfunction

	// store in the lowest free slot, or report a full table
	task automatic attach_id(input logic [ID_W-1:0] id, input logic [TIMEOUT_W-1:0] tmo);
		bit placed;
		placed = 1'b0;
		for (int i = 0; i < ENTRIES && !placed; i++) begin
			if (live_id[i] == '0) begin
				live_id[i]   = id;
				time_left[i] = tmo;
				awaited_results.push_back(make_result(ST_ATTACHED, id, i, 1'b1));
				placed = 1'b1;
			end
		end
		if (!placed) begin
			awaited_results.push_back(make_result(ST_FULL, id, 0, 1'b1));
		end
	endtask

	// update the table for one request item and queue the results it causes
	task automatic apply_request(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
		input logic [TIMEOUT_W-1:0] tmo);
		bit hit;
		hit = 1'b0;
		case (act)
			ACT_ATTACH: begin
				if (id == '0) begin
					awaited_results.push_back(make_result(ST_INVALID, '0, 0, 1'b1));
				end else begin
					attach_id(id, tmo);
				end
			end
			ACT_ALLOC: begin
				if (id_counter >= id_limit) begin
					id_counter = ID_W'(1);
				end else begin
					id_counter = id_counter + 1'b1;
				end
				attach_id(id_counter, tmo);
			end
			ACT_ACK: begin
				if (id == '0) begin
					awaited_results.push_back(make_result(ST_INVALID, '0, 0, 1'b1));
				end else begin
					for (int i = 0; i < ENTRIES && !hit; i++) begin
						if (live_id[i] == id) begin
							live_id[i]   = '0;
							time_left[i] = '0;
							awaited_results.push_back(make_result(ST_ACKED, id, i, 1'b1));
							hit = 1'b1;
						end
					end
					if (!hit) begin
						awaited_results.push_back(make_result(ST_NOT_FOUND, id, 0, 1'b1));
					end
				end
			end
			default: begin
				// age every live entry, expiring those at or below the step
				for (int i = 0; i < ENTRIES; i++) begin
					if (live_id[i] != '0) begin
						if (time_left[i] > TIMEOUT_W'(tick_step)) begin
							time_left[i] = time_left[i] - TIMEOUT_W'(tick_step);
						end else begin
							awaited_results.push_back(make_result(ST_EXPIRED, live_id[i], i, 1'b0));
							live_id[i]   = '0;
							time_left[i] = '0;
						end
					end
				end
				awaited_results.push_back(make_result(ST_TICK_END, '0, 0, 1'b1));
			end
		endcase
	endtask

	// register writes, prediction on request accept, compare on result accept
	always @(posedge clk or negedge arst_n) begin
		table_result_t seen;
		table_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				live_id[i]   = '0;
				time_left[i] = '0;
			end
			id_counter = NEXT_ID_RST;
			id_limit   = LIMIT_RST;
			tick_step  = AMOUNT_RST;
			awaited_results.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[REG_SEL_BIT] == REG_ID_LIMIT) begin
					id_limit = pwdata[ID_W-1:0];
				end else begin
					tick_step = pwdata[AMOUNT_W-1:0];
				end
			end
			if (req.valid && req.ready) begin
				apply_request(req.action, req.msg_id, req.timeout_ms);
			end
			if (rsp.valid && rsp.ready) begin
				seen = {rsp.status, rsp.result_id, rsp.slot, rsp.last};
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected item, expected none, got st=%0d id=%h slot=%0d last=%b",
						$time, seen.status, seen.result_id, seen.slot, seen.last);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (seen.status !== want.status || seen.result_id !== want.result_id ||
						seen.slot !== want.slot || seen.last !== want.last) begin
						$display("%0t: mismatch exp st=%0d id=%h slot=%0d last=%b got st=%0d id=%h slot=%0d last=%b",
							$time, want.status, want.result_id, want.slot, want.last,
							seen.status, seen.result_id, seen.slot, seen.last);
						mismatches++;
					end
				end
			end
		end
		outstanding = awaited_results.size();
	end

endmodule

// ----- test/pending_ack_table_with_timeout_tb.sv -----
module pending_ack_table_with_timeout_tb;
	import pat_pkg::*;

	localparam int PHASES           = 5;
	localparam int RANDOM_PER_PHASE = 49;
	localparam int DRAIN_CYCLES     = ENTRIES_DEF + 4;
	localparam int STALL_LIMIT      = 4000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int unsigned         outstanding;
	int unsigned         mismatches;
	int unsigned         quiet_cycles = 0;
	int                  sender_idle_pct;
	int                  recv_stall_pct;
	logic [AMOUNT_W-1:0] cur_tick;

	pat_in_if  req_ch();
	pat_out_if rsp_ch();

	pending_ack_table_with_timeout u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	pat_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure
	always @(negedge clk) begin
		rsp_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(1, 100) > recv_stall_pct);
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// offer one request item, with random idle cycles ahead of it
	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
		input logic [TIMEOUT_W-1:0] tmo);
		while (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.msg_id     <= id;
		req_ch.timeout_ms <= tmo;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// setup and access cycles, then an idle bus before returning
	task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(sel) << REG_SEL_BIT;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering items and let the table finish its work
	task automatic drain_requests();
		req_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic reconfigure(input logic [ID_W-1:0] limit, input logic [AMOUNT_W-1:0] tick);
		drain_requests();
		write_reg(REG_ID_LIMIT, PDATA_W'(limit));
		write_reg(REG_TICK_AMT, PDATA_W'(tick));
		cur_tick = tick;
	endtask

	initial begin
		logic [ACTION_W-1:0]  act;
		logic [ID_W-1:0]      id;
		logic [TIMEOUT_W-1:0] tmo;
		int                   r;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_ATTACH;
		req_ch.msg_id     = '0;
		req_ch.timeout_ms = '0;
		rsp_ch.ready      = 1'b0;
		sender_idle_pct   = 0;
		recv_stall_pct    = 0;
		cur_tick          = AMOUNT_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// invalid ids, miss on an empty table, tick with nothing live
		send_request(ACT_ATTACH, '0, 32'd50);
		send_request(ACT_ACK, '0, '0);
		send_request(ACT_ACK, 16'hffff, '0);
		send_request(ACT_TICK, '0, '0);
		// extreme id and timeout, zero timeout, duplicate ids
		send_request(ACT_ATTACH, 16'hffff, 32'hffff_ffff);
		send_request(ACT_ATTACH, 16'd1, 32'd0);
		send_request(ACT_ATTACH, 16'h1234, 32'd5000);
		send_request(ACT_ATTACH, 16'h1234, 32'd1001);
		// counter wraps to 1 on the first allocation, duplicating an attached id
		send_request(ACT_ALLOC, 16'hffff, 32'd1000);
		// acknowledge frees only the lowest match
		send_request(ACT_ACK, 16'd1, '0);
		send_request(ACT_ACK, 16'h1234, '0);
		// timeout equal to the step expires, one above it survives once
		send_request(ACT_TICK, '0, '0);
		send_request(ACT_TICK, '0, '0);
		// fill the table, then allocate and attach into a full table
		for (int n = 0; n < 7; n++) begin
			send_request(ACT_ALLOC, ID_W'(n), TIMEOUT_W'(n * 143));
		end
		send_request(ACT_ALLOC, '0, 32'd10);
		send_request(ACT_ATTACH, 16'h8000, 32'd10);
		// every slot expires on one tick
		send_request(ACT_ACK, 16'hffff, '0);
		send_request(ACT_ATTACH, 16'haaaa, 32'd0);
		send_request(ACT_TICK, '0, '0);

		// random phases with different registers and idle patterns
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					reconfigure(16'd5, 16'd1);
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
				end
				1: begin
					reconfigure(16'd1, 16'd65535);
					sender_idle_pct = 79;
					recv_stall_pct  = 0;
				end
				2: begin
					reconfigure(16'd65535, 16'd1000);
					sender_idle_pct = 0;
					recv_stall_pct  = 79;
				end
				3: begin
					reconfigure(16'd0, 16'd0);
					sender_idle_pct = 31;
					recv_stall_pct  = 31;
				end
				default: begin
					reconfigure(16'd20, 16'd300);
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					act = ACT_ATTACH;
				end else if (r < 55) begin
					act = ACT_ALLOC;
				end else if (r < 85) begin
					act = ACT_ACK;
				end else begin
					act = ACT_TICK;
				end
				// small id pool so acknowledges find their entries
				case ($urandom_range(0, 9))
					0: id = '0;
					1: id = '1;
					2: id = ID_W'($urandom);
					default: id = ID_W'($urandom_range(1, 12));
				endcase
				// timeouts mostly within a few ticks
				case ($urandom_range(0, 7))
					0: tmo = '0;
					1: tmo = '1;
					2: tmo = $urandom;
					default: tmo = $urandom_range(0, 4 * cur_tick + 1);
				endcase
				send_request(act, id, tmo);
			end
		end

		drain_requests();
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
